[hw/rtl/cdll_pkg.sv]
// ----------------------------------------------------------------------------
// cdll_pkg
// Shared types, codes and defaults for the circular doubly linked list block.
// ----------------------------------------------------------------------------
package cdll_pkg;

   localparam int NODES_DEFAULT = 16;

   localparam logic [2:0] KIND_INS_FRONT = 3'd0;
   localparam logic [2:0] KIND_INS_BACK  = 3'd1;
   localparam logic [2:0] KIND_INS_AFTER = 3'd2;
   localparam logic [2:0] KIND_DEL_FRONT = 3'd3;
   localparam logic [2:0] KIND_DEL_BACK  = 3'd4;
   localparam logic [2:0] KIND_DEL_KEY   = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // Datapath operation codes issued by the controller.
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_LOAD   = 3'd1; // capture request, start walk at head
   localparam logic [2:0] OP_STEP   = 3'd2; // compare current node, advance
   localparam logic [2:0] OP_INSERT = 3'd3; // link new node
   localparam logic [2:0] OP_DELETE = 3'd4; // unlink chosen node
   localparam logic [2:0] OP_FINISH = 3'd5; // no change, report status

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] status;
   } cdll_cmd_type;

   typedef struct packed {
      logic       empty;
      logic       full;
      logic       hit;   // current walk node holds the key
      logic       last;  // current walk node is the final one to examine
   } cdll_stat_type;

endpackage

[hw/rtl/cdll_datapath.sv]
// ----------------------------------------------------------------------------
// cdll_datapath
// Node pool, links, head, count and free map; executes controller commands.
// ----------------------------------------------------------------------------
module cdll_datapath #(
   parameter int NODES = cdll_pkg::NODES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [2:0]           req_kind,
   input  logic signed [31:0]   req_new_value,
   input  logic signed [31:0]   req_match_key,
   input  cdll_pkg::cdll_cmd_type cmd,
   output cdll_pkg::cdll_stat_type stat,
   output logic [1:0]           rsp_status,
   output logic signed [31:0]   rsp_removed_value,
   output logic [4:0]           rsp_entry_count
);
   import cdll_pkg::*;

   localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CW = $clog2(NODES + 1);

   logic [31:0]    value_mem [NODES];
   logic [IW-1:0]  next_mem  [NODES];
   logic [IW-1:0]  prev_mem  [NODES];

   logic [IW-1:0]  head_ff, head_in;
   logic [CW-1:0]  total_ff, total_in;
   logic [NODES-1:0] free_ff, free_in;

   logic [2:0]     kind_ff;
   logic [31:0]    val_ff, key_ff;
   logic [IW-1:0]  cur_ff;
   logic [CW-1:0]  cnt_ff;

   logic [IW-1:0]  slot;
   logic           full;

   always_comb begin
      slot = '0;
      for (int i = NODES - 1; i >= 0; i--) begin
         if (free_ff[i]) slot = IW'(i);
      end
   end
   assign full = (free_ff == '0);

   assign stat.empty = (total_ff == '0);
   assign stat.full  = full;
   assign stat.hit   = (value_mem[cur_ff] == key_ff);
   assign stat.last  = (cnt_ff + CW'(1) >= total_ff);

   // Insert / delete targets
   logic [IW-1:0] tail, ins_a, ins_b, del_s, del_p, del_n;
   assign tail  = prev_mem[head_ff];
   assign ins_a = (kind_ff == KIND_INS_AFTER) ? cur_ff : tail;
   assign ins_b = next_mem[ins_a];
   assign del_s = (kind_ff == KIND_DEL_FRONT) ? head_ff :
                  (kind_ff == KIND_DEL_BACK) ? tail : cur_ff;
   assign del_p = prev_mem[del_s];
   assign del_n = next_mem[del_s];

   always_comb begin
      head_in  = head_ff;
      total_in = total_ff;
      free_in  = free_ff;
      unique case (cmd.op)
         OP_INSERT: begin
            free_in[slot] = 1'b0;
            total_in = total_ff + CW'(1);
            if (total_ff == '0 || kind_ff == KIND_INS_FRONT) head_in = slot;
         end
         OP_DELETE: begin
            free_in[del_s] = 1'b1;
            if (total_ff <= CW'(1)) begin
               head_in  = '0;
               total_in = '0;
            end else begin
               total_in = total_ff - CW'(1);
               if (del_s == head_ff) head_in = del_n;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         total_ff <= '0;
         free_ff  <= '1;
      end else begin
         head_ff  <= head_in;
         total_ff <= total_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            kind_ff <= req_kind;
            val_ff  <= req_new_value;
            key_ff  <= req_match_key;
            cur_ff  <= head_ff;
            cnt_ff  <= '0;
         end
         OP_STEP: begin
            cur_ff <= next_mem[cur_ff];
            cnt_ff <= cnt_ff + CW'(1);
         end
         OP_INSERT: begin
            value_mem[slot] <= val_ff;
            if (total_ff == '0) begin
               next_mem[slot] <= slot;
               prev_mem[slot] <= slot;
            end else begin
               prev_mem[slot]  <= ins_a;
               next_mem[slot]  <= ins_b;
               prev_mem[ins_b] <= slot;
               next_mem[ins_a] <= slot;
            end
         end
         OP_DELETE: begin
            if (total_ff > CW'(1)) begin
               next_mem[del_p] <= del_n;
               prev_mem[del_n] <= del_p;
            end
         end
         default: ;
      endcase
   end

   // Result register: capture on the final command of a transaction.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_INSERT || cmd.op == OP_DELETE || cmd.op == OP_FINISH) begin
         rsp_status        <= cmd.status;
         rsp_removed_value <= (cmd.op == OP_DELETE) ? value_mem[del_s] : '0;
         rsp_entry_count   <= 5'(total_in);
      end
   end

endmodule

[hw/rtl/cdll_control.sv]
// ----------------------------------------------------------------------------
// cdll_control
// Sequencer: decodes the request, runs the key walk, issues datapath commands.
// ----------------------------------------------------------------------------
module cdll_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [2:0]              req_kind,
   input  cdll_pkg::cdll_stat_type stat,
   output cdll_pkg::cdll_cmd_type  cmd,
   output logic                    busy,
   output logic                    rsp_valid
);
   import cdll_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DEC  = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [2:0] kind_ff;
   logic       done_ff, done_in;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      cmd.op     = OP_NONE;
      cmd.status = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            done_in  = 1'b1;
            state_in = S_IDLE;
            unique case (kind_ff) inside
               KIND_INS_FRONT, KIND_INS_BACK: begin
                  if (stat.full) begin
                     cmd.op = OP_FINISH;  cmd.status = ST_FULL;
                  end else cmd.op = OP_INSERT;
               end
               KIND_INS_AFTER, KIND_DEL_KEY: begin
                  if (stat.empty) begin
                     cmd.op = OP_FINISH;  cmd.status = ST_EMPTY;
                  end else if (kind_ff == KIND_INS_AFTER && stat.full) begin
                     cmd.op = OP_FINISH;  cmd.status = ST_FULL;
                  end else begin
                     done_in  = 1'b0;
                     state_in = S_WALK;
                  end
               end
               KIND_DEL_FRONT, KIND_DEL_BACK: begin
                  if (stat.empty) begin
                     cmd.op = OP_FINISH;  cmd.status = ST_EMPTY;
                  end else cmd.op = OP_DELETE;
               end
               default: cmd.op = OP_FINISH;
            endcase
         end
         S_WALK: begin
            if (stat.hit) begin
               cmd.op   = (kind_ff == KIND_INS_AFTER) ? OP_INSERT : OP_DELETE;
               done_in  = 1'b1;
               state_in = S_IDLE;
            end else if (stat.last) begin
               cmd.op     = OP_FINISH;
               cmd.status = ST_NOTFOUND;
               done_in    = 1'b1;
               state_in   = S_IDLE;
            end else cmd.op = OP_STEP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) kind_ff <= req_kind;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = done_ff;

endmodule

[hw/rtl/circular_doubly_linked_list.sv]
// ----------------------------------------------------------------------------
// circular_doubly_linked_list
// Circular doubly linked list of signed 32-bit values in a fixed node pool.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req_kind/req_new_value/req_match_key while busy is low;
//   the transaction is taken on that edge and busy rises the next cycle.
//   Exactly one result per transaction appears on rsp_status,
//   rsp_removed_value and rsp_entry_count for one cycle, flagged by rsp_valid.
//   The receiver cannot stall; capture the result when rsp_valid is high.
// Timing:
//   Front/back operations and early rejects: the request is captured from idle,
//   decoded in S_DEC and its result registered; the next start is accepted in the
//   same cycle the result is shown. Key operations instead walk the list one node
//   per cycle from the head, examining up to NODES nodes, before the result is registered.
// Reset:
//   Synchronous reset empties the list, marks all nodes free, head zero.
//   The node memory is not cleared; only linked nodes are ever read.
// ----------------------------------------------------------------------------
module circular_doubly_linked_list #(
   parameter int NODES = cdll_pkg::NODES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_new_value,
   input  logic signed [31:0] req_match_key,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_removed_value,
   output logic [4:0]         rsp_entry_count
);
   import cdll_pkg::*;

   cdll_cmd_type  cmd;
   cdll_stat_type stat;

   // Sequence the transaction.
   cdll_control u_ctrl (
      .clock, .reset, .start, .req_kind, .stat, .cmd, .busy, .rsp_valid
   );

   // Hold the pool and execute commands.
   cdll_datapath #(.NODES(NODES)) u_dp (
      .clock, .reset, .req_kind, .req_new_value, .req_match_key, .cmd, .stat,
      .rsp_status, .rsp_removed_value, .rsp_entry_count
   );

`ifndef SYNTHESIS
   // Accepted transaction makes the block busy next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");
   // A result ends a busy period.
   a_valid_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without transaction");
   // Count never exceeds the pool.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_entry_count) <= NODES)) else $error("count overflow");
`endif

endmodule

[tb/cdll_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdll_checker
// Watches the request and response channels of the linked list block, keeps
// its own copy of the node pool and compares every response in order.
// ----------------------------------------------------------------------------
module cdll_checker #(
   parameter int NODES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_new_value,
   input  logic signed [31:0] req_match_key,
   input  logic               rsp_valid,
   input  logic [1:0]         rsp_status,
   input  logic signed [31:0] rsp_removed_value,
   input  logic [4:0]         rsp_entry_count,
   output int                 fail_count,
   output int                 pending_count,
   output int                 node_count
);
   import cdll_pkg::*;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] removed;
      logic [4:0]         count;
   } list_result_type;

   logic signed [31:0] pool_value [NODES];
   int                 pool_next  [NODES];
   int                 pool_prev  [NODES];
   logic [NODES-1:0]   pool_free;
   int                 head;
   int                 total;
   list_result_type    expected_q [$];

   assign pending_count = expected_q.size();
   assign node_count    = total;

   function automatic int take_slot();
      for (int i = 0; i < NODES; i++) begin
         if (pool_free[i]) begin
            pool_free[i] = 1'b0;
            return i;
         end
      end
      return NODES;
   endfunction

   function automatic void link_behind(int a, int s);
      int b;
      b = pool_next[a];
      pool_prev[s] = a;
      pool_next[s] = b;
      pool_prev[b] = s;
      pool_next[a] = s;
   endfunction

   function automatic logic signed [31:0] unlink(int s);
      logic signed [31:0] v;
      v = pool_value[s];
      if (total <= 1) begin
         head  = 0;
         total = 0;
      end else begin
         pool_next[pool_prev[s]] = pool_next[s];
         pool_prev[pool_next[s]] = pool_prev[s];
         if (s == head) head = pool_next[s];
         total--;
      end
      pool_free[s] = 1'b1;
      return v;
   endfunction

   function automatic int find_node(logic signed [31:0] key);
      int cur;
      cur = head;
      for (int k = 0; k < total; k++) begin
         if (pool_value[cur] == key) return cur;
         cur = pool_next[cur];
      end
      return NODES;
   endfunction

   function automatic list_result_type apply_op(logic [2:0] kind,
                                                logic signed [31:0] val,
                                                logic signed [31:0] key);
      list_result_type r;
      int s, t;
      r = '0;
      r.status = ST_OK;
      case (kind)
         KIND_INS_FRONT, KIND_INS_BACK: begin
            s = take_slot();
            if (s >= NODES) begin
               r.status = ST_FULL;
            end else begin
               pool_value[s] = val;
               if (total == 0) begin
                  pool_next[s] = s;
                  pool_prev[s] = s;
                  head = s;
               end else begin
                  link_behind(pool_prev[head], s);
                  if (kind == KIND_INS_FRONT) head = s;
               end
               total++;
            end
         end
         KIND_INS_AFTER: begin
            if (total == 0) r.status = ST_EMPTY;
            else if (pool_free == '0) r.status = ST_FULL;
            else begin
               t = find_node(key);
               if (t >= NODES) r.status = ST_NOTFOUND;
               else begin
                  s = take_slot();
                  pool_value[s] = val;
                  link_behind(t, s);
                  total++;
               end
            end
         end
         KIND_DEL_FRONT, KIND_DEL_BACK: begin
            if (total == 0) r.status = ST_EMPTY;
            else r.removed = unlink(kind == KIND_DEL_FRONT ? head : pool_prev[head]);
         end
         KIND_DEL_KEY: begin
            if (total == 0) r.status = ST_EMPTY;
            else begin
               t = find_node(key);
               if (t >= NODES) r.status = ST_NOTFOUND;
               else r.removed = unlink(t);
            end
         end
         default: ;
      endcase
      r.count = total[4:0];
      return r;
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         head      = 0;
         total     = 0;
         pool_free = '1;
         fail_count <= 0;
         expected_q.delete();
      end else begin
         // response first: a start may be taken on the edge its predecessor ends
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("%0t: response with nothing pending: st=%0d rm=%0d cnt=%0d",
                           $time, rsp_status, rsp_removed_value, rsp_entry_count);
            end else begin
               want = expected_q.pop_front();
               if (want.status !== rsp_status || want.removed !== rsp_removed_value ||
                   want.count !== rsp_entry_count) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("%0t: mismatch exp st=%0d rm=%0d cnt=%0d got st=%0d rm=%0d cnt=%0d",
                              $time, want.status, want.removed, want.count,
                              rsp_status, rsp_removed_value, rsp_entry_count);
               end
            end
         end
         if (start && !busy)
            expected_q.push_back(apply_op(req_kind, req_new_value, req_match_key));
      end
   end

endmodule

[tb/tb_circular_doubly_linked_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_doubly_linked_list
// Drives list operations into the block: a directed pass over empty, full,
// head and tail cases, then random operations under several idle patterns.
// ----------------------------------------------------------------------------
module tb_circular_doubly_linked_list;
   import cdll_pkg::*;

   localparam int NODES    = 16;
   localparam int WATCHDOG = 2000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_kind;
   logic signed [31:0] req_new_value;
   logic signed [31:0] req_match_key;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_removed_value;
   logic [4:0]         rsp_entry_count;
   int                 fail_count;
   int                 pending_count;
   int                 node_count;
   int                 idle_cycles;
   int                 idle_pct;
   logic signed [31:0] recent_values [$];

   circular_doubly_linked_list #(.NODES(NODES)) dut (.*);

   cdll_checker #(.NODES(NODES)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Count cycles where neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("** circular_doubly_linked_list: FAILED **");
         $finish;
      end
   end

   // Present one transaction and hold it until the edge that takes it.
   // Start stays high after the taking edge so the next one can follow.
   task automatic send_op(logic [2:0] kind, logic signed [31:0] val,
                          logic signed [31:0] key);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start         <= 1'b1;
      req_kind      <= kind;
      req_new_value <= val;
      req_match_key <= key;
      do @(posedge clock); while (busy);
      recent_values.push_back(val);
      if (recent_values.size() > 24) void'(recent_values.pop_front());
   endtask

   // Drop start and hold until every pending response is back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(7));
         default: return $signed($urandom());
      endcase
   endfunction

   // Favor keys already seen so searches hit often.
   function automatic logic signed [31:0] pick_key();
      if (recent_values.size() > 0 && $urandom_range(3) != 0)
         return recent_values[$urandom_range(recent_values.size() - 1)];
      return pick_value();
   endfunction

   task automatic random_phase(int count, int pct);
      logic [2:0] kind;
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         // bias toward inserts when short, deletes when nearly full
         if ($urandom_range(49) == 0)
            kind = KIND_DEL_KEY + 3'd1 + 3'($urandom_range(1));
         else if (node_count < 4 && $urandom_range(2) != 0)
            kind = KIND_INS_FRONT + 3'($urandom_range(2));
         else if (node_count > 12 && $urandom_range(2) != 0)
            kind = KIND_DEL_FRONT + 3'($urandom_range(2));
         else kind = KIND_INS_FRONT + 3'($urandom_range(5));
         send_op(kind, pick_value(), pick_key());
      end
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_kind      = KIND_INS_FRONT;
      req_new_value = '0;
      req_match_key = '0;
      idle_pct      = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list cases
      send_op(KIND_DEL_FRONT, 0, 0);
      send_op(KIND_DEL_BACK, 0, 0);
      send_op(KIND_DEL_KEY, 0, 0);
      send_op(KIND_INS_AFTER, 1, 0);
      // single node delete, then fill the pool to the top
      send_op(KIND_INS_BACK, 32'sh7fffffff, 0);
      send_op(KIND_DEL_KEY, 0, 32'sh7fffffff);
      for (int i = 0; i < NODES; i++)
         send_op(i[0] ? KIND_INS_FRONT : KIND_INS_BACK, 32'sh80000000 + i, 0);
      send_op(KIND_INS_FRONT, -1, 0);
      send_op(KIND_INS_AFTER, -1, 32'sh80000000);
      send_op(KIND_DEL_KEY, 0, 32'sh80000001);
      send_op(KIND_DEL_KEY, 0, 12345);
      send_op(KIND_INS_AFTER, 5, 32'sh80000000);
      send_op(KIND_DEL_KEY + 3'd2, 0, 0);
      drain();

      random_phase(500, 0);
      drain();
      random_phase(500, 53);
      random_phase(500, 26);
      random_phase(500, 0);
      drain();

      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("** circular_doubly_linked_list: PASSED **");
      else
         $display("** circular_doubly_linked_list: FAILED **");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/cdll_pkg.sv
hw/rtl/cdll_datapath.sv
hw/rtl/cdll_control.sv
hw/rtl/circular_doubly_linked_list.sv
tb/cdll_checker.sv
tb/tb_circular_doubly_linked_list.sv
